FILE: src/jsp_pkg.sv
// ============================================================================
// jsp_pkg
// Shared types and constants for the JSON structural parser.
// ============================================================================
package jsp_pkg;

    localparam int DEFAULT_MAX_DEPTH = 32;
    localparam int FIFO_DEPTH        = 2;
    localparam int DEPTH_OUT_W       = 6;

    localparam logic [7:0] CFG_MAX_CHARS_RESET = 8'd255;

    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;

    typedef enum logic [3:0] {
        CL_WS,
        CL_LBRACE,
        CL_LBRACKET,
        CL_RBRACE,
        CL_RBRACKET,
        CL_COLON,
        CL_COMMA,
        CL_QUOTE,
        CL_OTHER
    } cls_t;

    typedef enum logic [3:0] {
        ST_START,
        ST_OBJ_NEW,
        ST_ARR_NEW,
        ST_COLON,
        ST_OBJ_NEXT,
        ST_ARR_NEXT,
        ST_VALUE,
        ST_KEY_STR,
        ST_VAL_STR
    } stage_t;

    typedef enum logic [3:0] {
        EV_SKIP   = 4'd0,
        EV_OBJ    = 4'd1,
        EV_ARR    = 4'd2,
        EV_CLOSE  = 4'd3,
        EV_SBEGIN = 4'd4,
        EV_SCHAR  = 4'd5,
        EV_SEND   = 4'd6,
        EV_DONE   = 4'd7,
        EV_ERROR  = 4'd8
    } event_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_BYTE  = 2'd1,
        ERR_LONG  = 2'd2,
        ERR_DEEP  = 2'd3
    } err_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_HALTED,
        ACT_OPEN_OBJ,
        ACT_OPEN_ARR,
        ACT_CLOSE,
        ACT_BEGIN_KEY,
        ACT_BEGIN_VAL,
        ACT_SCHAR,
        ACT_SEND,
        ACT_TO_VALUE,
        ACT_TO_OBJ_NEW,
        ACT_TO_ARR_NEW,
        ACT_ERR_BYTE,
        ACT_ERR_LONG,
        ACT_ERR_DEEP
    } act_t;

    typedef struct packed {
        logic [7:0] data;
        cls_t       cls;
    } item_t;

    typedef struct packed {
        event_t                 ev;
        logic [7:0]             data;
        logic                   is_key;
        logic [DEPTH_OUT_W-1:0] depth;
        err_t                   err;
        logic                   halted;
    } result_t;

endpackage

FILE: src/jsp_ram.sv
// ============================================================================
// jsp_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module jsp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/jsp_front.sv
// ============================================================================
// jsp_front
// Input stage: takes raw bytes, classifies them, holds one item for the queue.
// ============================================================================
module jsp_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    output logic          out_valid,
    input  logic          out_ready,
    output jsp_pkg::item_t out_item
);
    import jsp_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;
    cls_t  cls;

    always_comb begin
        case (in_byte)
            CH_SPACE, CH_TAB, CH_NEWLINE: cls = CL_WS;
            CH_LBRACE:                    cls = CL_LBRACE;
            CH_LBRACKET:                  cls = CL_LBRACKET;
            CH_RBRACE:                    cls = CL_RBRACE;
            CH_RBRACKET:                  cls = CL_RBRACKET;
            CH_COLON:                     cls = CL_COLON;
            CH_COMMA:                     cls = CL_COMMA;
            CH_QUOTE:                     cls = CL_QUOTE;
            default:                      cls = CL_OTHER;
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg.data <= in_byte;
            item_reg.cls  <= cls;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: src/jsp_fifo.sv
// ============================================================================
// jsp_fifo
// Short item queue between the classifier and the parser.
// ============================================================================
module jsp_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    output logic           full_n,
    input  jsp_pkg::item_t push_item,
    input  logic           pop,
    output logic           empty_n,
    output jsp_pkg::item_t pop_item
);
    import jsp_pkg::*;

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

    item_t         slots [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full_n   = (count_reg != FULL_CNT);
    assign empty_n  = (count_reg != '0);
    assign do_push  = push && full_n;
    assign do_pop   = pop && empty_n;
    assign pop_item = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: src/jsp_back.sv
// ============================================================================
// jsp_back
// Parser core: stage machine, container stack, string counter, result register.
// ============================================================================
module jsp_back #(
    parameter int MAX_DEPTH = jsp_pkg::DEFAULT_MAX_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [7:0]       max_chars,
    input  logic             in_valid,
    output logic             in_ready,
    input  jsp_pkg::item_t   in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output jsp_pkg::result_t out_res
);
    import jsp_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam logic [DW-1:0] DEPTH_FULL = DW'(MAX_DEPTH);

    stage_t        stage_reg, stage_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [7:0]    slen_reg, slen_next;
    logic          halt_reg, halt_next;
    logic          top_reg, top_next;
    logic          valid_reg, valid_next;
    result_t       res_reg, res_next;

    act_t          act;
    logic          fire;
    logic          below_kind;
    logic          push_we;
    logic [AW-1:0] rd_addr;
    logic          str_key;
    event_t        ev;
    err_t          err;
    logic          key;

    assign in_ready = !valid_reg || out_ready;
    assign fire     = in_valid && in_ready;
    assign str_key  = (stage_reg == ST_KEY_STR);

    // decode
    always_comb begin
        act = ACT_ERR_BYTE;
        if (halt_reg) begin
            act = ACT_HALTED;
        end else if (stage_reg == ST_KEY_STR || stage_reg == ST_VAL_STR) begin
            if (in_item.cls == CL_QUOTE) begin
                act = ACT_SEND;
            end else if (slen_reg >= max_chars) begin
                act = ACT_ERR_LONG;
            end else begin
                act = ACT_SCHAR;
            end
        end else if (in_item.cls == CL_WS) begin
            act = ACT_NONE;
        end else begin
            case (stage_reg)
                ST_START: begin
                    if (in_item.cls == CL_LBRACE)        act = ACT_OPEN_OBJ;
                    else if (in_item.cls == CL_LBRACKET) act = ACT_OPEN_ARR;
                end
                ST_OBJ_NEW: begin
                    if (in_item.cls == CL_QUOTE)         act = ACT_BEGIN_KEY;
                    else if (in_item.cls == CL_RBRACE)   act = ACT_CLOSE;
                end
                ST_ARR_NEW: begin
                    if (in_item.cls == CL_QUOTE)         act = ACT_BEGIN_VAL;
                    else if (in_item.cls == CL_LBRACE)   act = ACT_OPEN_OBJ;
                    else if (in_item.cls == CL_LBRACKET) act = ACT_OPEN_ARR;
                    else if (in_item.cls == CL_RBRACKET) act = ACT_CLOSE;
                end
                ST_COLON: begin
                    if (in_item.cls == CL_COLON)         act = ACT_TO_VALUE;
                end
                ST_OBJ_NEXT: begin
                    if (in_item.cls == CL_COMMA)         act = ACT_TO_OBJ_NEW;
                    else if (in_item.cls == CL_RBRACE)   act = ACT_CLOSE;
                end
                ST_ARR_NEXT: begin
                    if (in_item.cls == CL_COMMA)         act = ACT_TO_ARR_NEW;
                    else if (in_item.cls == CL_RBRACKET) act = ACT_CLOSE;
                end
                ST_VALUE: begin
                    if (in_item.cls == CL_QUOTE)         act = ACT_BEGIN_VAL;
                    else if (in_item.cls == CL_LBRACE)   act = ACT_OPEN_OBJ;
                    else if (in_item.cls == CL_LBRACKET) act = ACT_OPEN_ARR;
                end
                default: act = ACT_ERR_BYTE;
            endcase
            if ((act == ACT_OPEN_OBJ || act == ACT_OPEN_ARR) && depth_reg >= DEPTH_FULL) begin
                act = ACT_ERR_DEEP;
            end
            if (act == ACT_CLOSE && depth_reg == '0) begin
                act = ACT_ERR_BYTE;
            end
        end
    end

    // next state
    always_comb begin
        stage_next = stage_reg;
        depth_next = depth_reg;
        slen_next  = slen_reg;
        halt_next  = halt_reg;
        top_next   = top_reg;
        push_we    = 1'b0;
        if (fire) begin
            case (act)
                ACT_OPEN_OBJ, ACT_OPEN_ARR: begin
                    push_we    = 1'b1;
                    top_next   = (act == ACT_OPEN_OBJ);
                    depth_next = depth_reg + DW'(1);
                    stage_next = (act == ACT_OPEN_OBJ) ? ST_OBJ_NEW : ST_ARR_NEW;
                end
                ACT_CLOSE: begin
                    depth_next = depth_reg - DW'(1);
                    if (depth_reg == DW'(1)) begin
                        halt_next = 1'b1;
                    end else begin
                        top_next   = below_kind;
                        stage_next = below_kind ? ST_OBJ_NEXT : ST_ARR_NEXT;
                    end
                end
                ACT_BEGIN_KEY: begin
                    slen_next  = '0;
                    stage_next = ST_KEY_STR;
                end
                ACT_BEGIN_VAL: begin
                    slen_next  = '0;
                    stage_next = ST_VAL_STR;
                end
                ACT_SCHAR: slen_next = slen_reg + 8'd1;
                ACT_SEND: begin
                    if (str_key) begin
                        stage_next = ST_COLON;
                    end else if (depth_reg == '0) begin
                        stage_next = ST_START;
                    end else begin
                        stage_next = top_reg ? ST_OBJ_NEXT : ST_ARR_NEXT;
                    end
                end
                ACT_TO_VALUE:   stage_next = ST_VALUE;
                ACT_TO_OBJ_NEW: stage_next = ST_OBJ_NEW;
                ACT_TO_ARR_NEW: stage_next = ST_ARR_NEW;
                ACT_ERR_BYTE, ACT_ERR_LONG, ACT_ERR_DEEP: halt_next = 1'b1;
                default: ;
            endcase
        end
    end

    // outputs
    always_comb begin
        ev  = EV_SKIP;
        err = ERR_NONE;
        key = 1'b0;
        case (act)
            ACT_OPEN_OBJ:  ev = EV_OBJ;
            ACT_OPEN_ARR:  ev = EV_ARR;
            ACT_CLOSE:     ev = (depth_reg == DW'(1)) ? EV_DONE : EV_CLOSE;
            ACT_BEGIN_KEY: begin
                ev  = EV_SBEGIN;
                key = 1'b1;
            end
            ACT_BEGIN_VAL: ev = EV_SBEGIN;
            ACT_SCHAR: begin
                ev  = EV_SCHAR;
                key = str_key;
            end
            ACT_SEND: begin
                ev  = EV_SEND;
                key = str_key;
            end
            ACT_ERR_BYTE: begin
                ev  = EV_ERROR;
                err = ERR_BYTE;
            end
            ACT_ERR_LONG: begin
                ev  = EV_ERROR;
                err = ERR_LONG;
            end
            ACT_ERR_DEEP: begin
                ev  = EV_ERROR;
                err = ERR_DEEP;
            end
            default: ev = EV_SKIP;
        endcase
        res_next.ev     = ev;
        res_next.data   = in_item.data;
        res_next.is_key = key;
        res_next.depth  = DEPTH_OUT_W'(depth_next);
        res_next.err    = err;
        res_next.halted = halt_next;
    end

    always_comb begin
        valid_next = valid_reg;
        if (fire) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    // stack of container kinds; read address tracks the entry under the new top
    assign rd_addr = (depth_next >= DW'(2)) ? AW'(depth_next - DW'(2)) : '0;

    jsp_ram #(
        .WIDTH (1),
        .DEPTH (MAX_DEPTH),
        .AW    (AW)
    ) u_stack (
        .aclk  (aclk),
        .we    (push_we),
        .waddr (AW'(depth_reg)),
        .wdata (top_next),
        .raddr (rd_addr),
        .rdata (below_kind)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= ST_START;
            depth_reg <= '0;
            slen_reg  <= '0;
            halt_reg  <= 1'b0;
            top_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            stage_reg <= stage_next;
            depth_reg <= depth_next;
            slen_reg  <= slen_next;
            halt_reg  <= halt_next;
            top_reg   <= top_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

FILE: src/json_structural_parser.sv
// ============================================================================
// json_structural_parser
// Checks a byte stream against a JSON subset, one structural event per byte.
// ============================================================================
//  channel | direction | payload
//  s_      | in        | s_tdata[7:0] in_byte
//  m_      | out       | m_tdata: data_byte, depth, error_kind, halted; m_tuser: event, is_key
//  cfg_    | in        | cfg_data[7:0] max_string_chars
//
//  One byte per cycle sustained while m_tready stays high; s_ bytes reach m_ through
//  the classify register, the queue and the parser result register.
//  The container stack is a RAM with registered read, prefetching the entry
//  under the top so a close does not wait on a stack read.
//  aresetn clears the parser state and sets max_string_chars to 255.
//  A stalled m_ side fills the queue, then drops s_tready.
module json_structural_parser #(
    parameter int MAX_DEPTH = jsp_pkg::DEFAULT_MAX_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [13:8] depth, [15:14] error_kind,
                                   // [16] halted, [23:17] zero
    output logic [4:0]  m_tuser,   // [3:0] event_res, [4] is_key
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // [7:0] max_string_chars
);
    import jsp_pkg::*;

    logic [7:0] max_chars_reg;
    logic       front_valid, fifo_full_n, fifo_empty_n, back_ready;
    item_t      front_item, fifo_item;
    result_t    res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_chars_reg <= CFG_MAX_CHARS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_chars_reg <= cfg_data;
        end
    end

    jsp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .out_valid (front_valid),
        .out_ready (fifo_full_n),
        .out_item  (front_item)
    );

    jsp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_valid),
        .full_n    (fifo_full_n),
        .push_item (front_item),
        .pop       (back_ready),
        .empty_n   (fifo_empty_n),
        .pop_item  (fifo_item)
    );

    jsp_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .max_chars (max_chars_reg),
        .in_valid  (fifo_empty_n),
        .in_ready  (back_ready),
        .in_item   (fifo_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {7'd0, res.halted, res.err, res.depth, res.data};
    assign m_tuser = {res.is_key, res.ev};

endmodule

FILE: src/jsp_checker.sv
// ============================================================================
// jsp_checker
// Port-level checks on the parser's result stream.
// ============================================================================
module jsp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [4:0]  m_tuser
);
    import jsp_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tdata[16] |=> !m_tvalid || m_tdata[16])
        else $error("halted dropped");

    a_err_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser[3:0] == EV_ERROR) == (m_tdata[15:14] != ERR_NONE)))
        else $error("error kind mismatch");

    a_key_string: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[4] |-> (m_tuser[3:0] == EV_SBEGIN || m_tuser[3:0] == EV_SCHAR
                                    || m_tuser[3:0] == EV_SEND))
        else $error("key flag outside string");

    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3:0] == EV_DONE |-> m_tdata[13:8] == 6'd0 && m_tdata[16])
        else $error("done without depth zero and halt");

endmodule

bind json_structural_parser jsp_checker u_jsp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
